// File: hw/rtl/mwm_pkg.sv
// shared types and constants for the mecanum wheel mixer
package mwm_pkg;

  // wheel lanes, order front left, front right, back left, back right
  localparam int NUM_WHEELS = 4;
  localparam int WHEEL_FL   = 0;
  localparam int WHEEL_FR   = 1;
  localparam int WHEEL_BL   = 2;
  localparam int WHEEL_BR   = 3;

  // field widths
  localparam int VEL_W   = 12;
  localparam int LIMIT_W = 11;
  localparam int DUTY_W  = 16;
  localparam int DIR_W   = 2;
  localparam int LEVEL_W = 24;

  // speed limit after reset
  localparam logic [LIMIT_W-1:0] SPEED_LIMIT_RESET = 11'd80;

  // sign pattern per wheel: bit set means the term is subtracted
  localparam logic [NUM_WHEELS-1:0] VY_NEG = 4'b1001;
  localparam logic [NUM_WHEELS-1:0] WZ_NEG = 4'b0101;

  // 0.77 as 197/256
  localparam logic signed [19:0] ROT_COEF = 20'sd197;

  // floor(n/25) = (n * RECIP_25) >> 31 for n < 2^26
  localparam logic [26:0] RECIP_25       = 27'd85899346;
  localparam int          RECIP_25_SHIFT = 31;

  // floor(n/5) = (n * RECIP_5) >> 29 for n < 2^26
  localparam logic [26:0] RECIP_5        = 27'd107374183;
  localparam int          RECIP_5_SHIFT  = 29;

  // direction codes
  typedef enum logic [DIR_W-1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd2
  } dir_t;

endpackage

// File: hw/rtl/mecanum_wheel_mixer.sv
// mecanum wheel mixer: clamp, mix, scale, smooth and duty/direction per wheel
// an accepted transaction passes stage 1, stage 2 and the result register to out_valid
// one transaction per cycle unless stalled; the smoothing loop closes in the last stage
// each stage holds its item only while the stage behind it is full and stalled
// rst_n is synchronous: clears the pipeline valids and the wheel levels, and
// sets the speed limit back to 80
module mecanum_wheel_mixer (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_wr_en,
  input  logic [mwm_pkg::LIMIT_W-1:0]       cfg_wr_data,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [mwm_pkg::VEL_W-1:0]  in_vel_x,
  input  logic signed [mwm_pkg::VEL_W-1:0]  in_vel_y,
  input  logic signed [mwm_pkg::VEL_W-1:0]  in_rot_z,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mwm_pkg::DUTY_W-1:0]        out_duty_front_left,
  output logic [mwm_pkg::DIR_W-1:0]         out_dir_front_left,
  output logic [mwm_pkg::DUTY_W-1:0]        out_duty_front_right,
  output logic [mwm_pkg::DIR_W-1:0]         out_dir_front_right,
  output logic [mwm_pkg::DUTY_W-1:0]        out_duty_back_left,
  output logic [mwm_pkg::DIR_W-1:0]         out_dir_back_left,
  output logic [mwm_pkg::DUTY_W-1:0]        out_duty_back_right,
  output logic [mwm_pkg::DIR_W-1:0]         out_dir_back_right
);

  localparam int NW = mwm_pkg::NUM_WHEELS;

  // configuration register
  logic [mwm_pkg::LIMIT_W-1:0] speed_limit_r;

  // stage 1: captured command
  logic                              s1_valid_r;
  logic signed [mwm_pkg::VEL_W-1:0]  s1_vx_r;
  logic signed [mwm_pkg::VEL_W-1:0]  s1_vy_r;
  logic signed [mwm_pkg::VEL_W-1:0]  s1_wz_r;

  // stage 2: scaled wheel targets, signed Q16
  logic                     s2_valid_r;
  logic signed [21:0]       target_r   [NW];
  logic signed [21:0]       target_nxt [NW];

  // result stage and smoothed levels
  logic                                 out_valid_r;
  logic [mwm_pkg::DUTY_W-1:0]           duty_r    [NW];
  logic [mwm_pkg::DUTY_W-1:0]           duty_nxt  [NW];
  mwm_pkg::dir_t                        dir_r     [NW];
  mwm_pkg::dir_t                        dir_nxt   [NW];
  logic signed [mwm_pkg::LEVEL_W-1:0]   level_r   [NW];
  logic signed [mwm_pkg::LEVEL_W-1:0]   level_nxt [NW];

  // per-stage flow control
  logic ready_out;
  logic ready_s2;
  logic ready_s1;

  assign ready_out = !out_valid_r || !out_stall;
  assign ready_s2  = !s2_valid_r || ready_out;
  assign ready_s1  = !s1_valid_r || ready_s2;
  assign in_stall  = !ready_s1;

  // speed limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_limit_r <= mwm_pkg::SPEED_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      speed_limit_r <= cfg_wr_data;
    end
  end

  // stage 1 capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (ready_s1) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && ready_s1) begin
      s1_vx_r <= in_vel_x;
      s1_vy_r <= in_vel_y;
      s1_wz_r <= in_rot_z;
    end
  end

  // clamp vx and vy, form 197*wz
  logic signed [12:0] lim_pos;
  logic signed [12:0] lim_neg;
  logic signed [12:0] vx_ext;
  logic signed [12:0] vy_ext;
  logic signed [12:0] vx_clamp;
  logic signed [12:0] vy_clamp;
  logic signed [19:0] wz_scaled;

  always_comb begin
    lim_pos = $signed({2'b00, speed_limit_r});
    lim_neg = -lim_pos;
    vx_ext  = {s1_vx_r[mwm_pkg::VEL_W-1], s1_vx_r};
    vy_ext  = {s1_vy_r[mwm_pkg::VEL_W-1], s1_vy_r};

    if (vx_ext > lim_pos) begin
      vx_clamp = lim_pos;
    end else if (vx_ext < lim_neg) begin
      vx_clamp = lim_neg;
    end else begin
      vx_clamp = vx_ext;
    end

    if (vy_ext > lim_pos) begin
      vy_clamp = lim_pos;
    end else if (vy_ext < lim_neg) begin
      vy_clamp = lim_neg;
    end else begin
      vy_clamp = vy_ext;
    end

    wz_scaled = $signed({{8{s1_wz_r[mwm_pkg::VEL_W-1]}}, s1_wz_r}) * mwm_pkg::ROT_COEF;
  end

  genvar gi;
  generate
    for (gi = 0; gi < NW; gi++) begin : g_wheel
      // mix in Q8 and scale by 256/200, truncating toward zero
      logic signed [12:0] lin_sum;
      logic signed [21:0] mix_q8;
      logic               mix_neg;
      logic [21:0]        mix_abs;
      logic [25:0]        mix_num;
      logic [52:0]        mix_prod;
      logic [20:0]        tgt_mag;

      always_comb begin
        lin_sum  = mwm_pkg::VY_NEG[gi] ? (vx_clamp - vy_clamp) : (vx_clamp + vy_clamp);
        mix_q8   = mwm_pkg::WZ_NEG[gi]
                 ? ($signed({lin_sum[12], lin_sum, 8'b0})
                    - $signed({{2{wz_scaled[19]}}, wz_scaled}))
                 : ($signed({lin_sum[12], lin_sum, 8'b0})
                    + $signed({{2{wz_scaled[19]}}, wz_scaled}));
        mix_neg  = mix_q8[21];
        mix_abs  = mix_neg ? 22'(-mix_q8) : 22'(mix_q8);
        mix_num  = {mix_abs[20:0], 5'b0};
        mix_prod = 53'(mix_num) * 53'(mwm_pkg::RECIP_25);
        tgt_mag  = mix_prod[mwm_pkg::RECIP_25_SHIFT +: 21];
        target_nxt[gi] = mix_neg ? -$signed({1'b0, tgt_mag}) : $signed({1'b0, tgt_mag});
      end

      // smoothing: level = (19*level + target) / 20, truncating toward zero
      logic signed [28:0] lvl_ext;
      logic signed [28:0] acc;
      logic               acc_neg;
      logic [28:0]        acc_abs;
      logic [25:0]        acc_quarter;
      logic [52:0]        acc_prod;
      logic [23:0]        lvl_mag;

      always_comb begin
        lvl_ext     = {{5{level_r[gi][mwm_pkg::LEVEL_W-1]}}, level_r[gi]};
        acc         = (lvl_ext <<< 4) + (lvl_ext <<< 1) + lvl_ext
                    + $signed({{7{target_r[gi][21]}}, target_r[gi]});
        acc_neg     = acc[28];
        acc_abs     = acc_neg ? 29'(-acc) : 29'(acc);
        acc_quarter = acc_abs[27:2];
        acc_prod    = 53'(acc_quarter) * 53'(mwm_pkg::RECIP_5);
        lvl_mag     = acc_prod[mwm_pkg::RECIP_5_SHIFT +: 24];
        level_nxt[gi] = acc_neg ? -$signed(lvl_mag) : $signed(lvl_mag);

        // duty saturates at full scale
        duty_nxt[gi] = (|lvl_mag[23:16]) ? {mwm_pkg::DUTY_W{1'b1}} : lvl_mag[15:0];
        if (lvl_mag == 24'd0) begin
          dir_nxt[gi] = mwm_pkg::DIR_STOP;
        end else if (acc_neg) begin
          dir_nxt[gi] = mwm_pkg::DIR_REV;
        end else begin
          dir_nxt[gi] = mwm_pkg::DIR_FWD;
        end
      end

      // target register
      always_ff @(posedge clk) begin
        if (s1_valid_r && ready_s2) begin
          target_r[gi] <= target_nxt[gi];
        end
      end

      // level state and result register
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          level_r[gi] <= '0;
        end else if (s2_valid_r && ready_out) begin
          level_r[gi] <= level_nxt[gi];
        end
      end

      always_ff @(posedge clk) begin
        if (s2_valid_r && ready_out) begin
          duty_r[gi] <= duty_nxt[gi];
          dir_r[gi]  <= dir_nxt[gi];
        end
      end
    end
  endgenerate

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ready_s2) begin
        s2_valid_r <= s1_valid_r;
      end
      if (ready_out) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  // result ports
  assign out_valid            = out_valid_r;
  assign out_duty_front_left  = duty_r[mwm_pkg::WHEEL_FL];
  assign out_dir_front_left   = dir_r[mwm_pkg::WHEEL_FL];
  assign out_duty_front_right = duty_r[mwm_pkg::WHEEL_FR];
  assign out_dir_front_right  = dir_r[mwm_pkg::WHEEL_FR];
  assign out_duty_back_left   = duty_r[mwm_pkg::WHEEL_BL];
  assign out_dir_back_left    = dir_r[mwm_pkg::WHEEL_BL];
  assign out_duty_back_right  = duty_r[mwm_pkg::WHEEL_BR];
  assign out_dir_back_right   = dir_r[mwm_pkg::WHEEL_BR];

endmodule

// File: hw/rtl/mwm_checker.sv
// port-level checks for the mecanum wheel mixer, bound to the top level
module mwm_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_stall,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [mwm_pkg::DUTY_W-1:0]        out_duty_front_left,
  input  logic [mwm_pkg::DIR_W-1:0]         out_dir_front_left,
  input  logic [mwm_pkg::DUTY_W-1:0]        out_duty_front_right,
  input  logic [mwm_pkg::DIR_W-1:0]         out_dir_front_right,
  input  logic [mwm_pkg::DUTY_W-1:0]        out_duty_back_left,
  input  logic [mwm_pkg::DIR_W-1:0]         out_dir_back_left,
  input  logic [mwm_pkg::DUTY_W-1:0]        out_duty_back_right,
  input  logic [mwm_pkg::DIR_W-1:0]         out_dir_back_right
);

  // a stalled result transaction stays offered
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result transaction dropped while stalled");

  // a stalled result transaction keeps its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_duty_front_left) && $stable(out_dir_front_left)
      && $stable(out_duty_front_right) && $stable(out_dir_front_right)
      && $stable(out_duty_back_left) && $stable(out_dir_back_left)
      && $stable(out_duty_back_right) && $stable(out_dir_back_right))
    else $error("result payload changed while stalled");

  // a stopped wheel has zero duty, a driven wheel a nonzero one
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      ((out_dir_front_left  == mwm_pkg::DIR_STOP) == (out_duty_front_left  == '0)) &&
      ((out_dir_front_right == mwm_pkg::DIR_STOP) == (out_duty_front_right == '0)) &&
      ((out_dir_back_left   == mwm_pkg::DIR_STOP) == (out_duty_back_left   == '0)) &&
      ((out_dir_back_right  == mwm_pkg::DIR_STOP) == (out_duty_back_right  == '0)))
    else $error("direction and duty disagree on a stopped wheel");

  // the input only stalls under result back-pressure
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_stall)
    else $error("input stalled without result back-pressure");

  // reset empties the pipeline
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind mecanum_wheel_mixer mwm_checker u_mwm_checker (.*);

// File: sim/mecanum_wheel_mixer_tb.sv
// self-checking testbench for the mecanum wheel mixer with its own wheel-level predictor
`timescale 1ns / 100ps

module mecanum_wheel_mixer_tb;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 9;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD    = 200;
  localparam int DUTY_MAX     = 65535;
  localparam int ROT_NUM      = 197;

  // expected drive of all four wheels for one transaction, index order FL, FR, BL, BR
  typedef struct packed {
    logic [mwm_pkg::NUM_WHEELS-1:0][mwm_pkg::DUTY_W-1:0] duty;
    logic [mwm_pkg::NUM_WHEELS-1:0][mwm_pkg::DIR_W-1:0]  dir;
  } wheel_drive_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [mwm_pkg::LIMIT_W-1:0] cfg_wr_data;
  logic in_valid;
  logic in_stall;
  logic signed [mwm_pkg::VEL_W-1:0] in_vel_x;
  logic signed [mwm_pkg::VEL_W-1:0] in_vel_y;
  logic signed [mwm_pkg::VEL_W-1:0] in_rot_z;
  logic out_valid;
  logic out_stall;
  logic [mwm_pkg::DUTY_W-1:0] out_duty_front_left;
  logic [mwm_pkg::DIR_W-1:0]  out_dir_front_left;
  logic [mwm_pkg::DUTY_W-1:0] out_duty_front_right;
  logic [mwm_pkg::DIR_W-1:0]  out_dir_front_right;
  logic [mwm_pkg::DUTY_W-1:0] out_duty_back_left;
  logic [mwm_pkg::DIR_W-1:0]  out_dir_back_left;
  logic [mwm_pkg::DUTY_W-1:0] out_duty_back_right;
  logic [mwm_pkg::DIR_W-1:0]  out_dir_back_right;

  mecanum_wheel_mixer uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_vel_x             (in_vel_x),
    .in_vel_y             (in_vel_y),
    .in_rot_z             (in_rot_z),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_duty_front_left  (out_duty_front_left),
    .out_dir_front_left   (out_dir_front_left),
    .out_duty_front_right (out_duty_front_right),
    .out_dir_front_right  (out_dir_front_right),
    .out_duty_back_left   (out_duty_back_left),
    .out_dir_back_left    (out_dir_back_left),
    .out_duty_back_right  (out_duty_back_right),
    .out_dir_back_right   (out_dir_back_right)
  );

  // predictor state: speed limit and smoothed wheel levels (signed Q16)
  logic [mwm_pkg::LIMIT_W-1:0]        limit_model;
  logic signed [mwm_pkg::LEVEL_W-1:0] level_model [mwm_pkg::NUM_WHEELS];
  wheel_drive_t                       pending_drive_q [$];

  int  mismatch_count = 0;
  int  cycle_count = 0;
  int  sender_idle_pct;
  int  receiver_stall_pct;
  bit  long_hold_on;
  event long_hold_ev;

  string wheel_name [mwm_pkg::NUM_WHEELS] =
    '{"front_left", "front_right", "back_left", "back_right"};

  // observed result, gathered into lanes
  logic [mwm_pkg::NUM_WHEELS-1:0][mwm_pkg::DUTY_W-1:0] seen_duty;
  logic [mwm_pkg::NUM_WHEELS-1:0][mwm_pkg::DIR_W-1:0]  seen_dir;

  assign seen_duty[mwm_pkg::WHEEL_FL] = out_duty_front_left;
  assign seen_duty[mwm_pkg::WHEEL_FR] = out_duty_front_right;
  assign seen_duty[mwm_pkg::WHEEL_BL] = out_duty_back_left;
  assign seen_duty[mwm_pkg::WHEEL_BR] = out_duty_back_right;
  assign seen_dir[mwm_pkg::WHEEL_FL]  = out_dir_front_left;
  assign seen_dir[mwm_pkg::WHEEL_FR]  = out_dir_front_right;
  assign seen_dir[mwm_pkg::WHEEL_BL]  = out_dir_back_left;
  assign seen_dir[mwm_pkg::WHEEL_BR]  = out_dir_back_right;

  // clock
  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off while one is requested
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= long_hold_on || ($urandom_range(0, 99) < receiver_stall_pct);
    end
  end

  // long hold-off, counted in its own process
  initial begin
    long_hold_on = 1'b0;
    forever begin
      @(long_hold_ev);
      @(posedge clk);
      long_hold_on = 1'b1;
      repeat (LONG_HOLD) @(posedge clk);
      long_hold_on = 1'b0;
    end
  end

  // clamp, mix, scale and smooth one command; updates the predicted levels
  function automatic wheel_drive_t predict_wheel_drive(
    input logic signed [mwm_pkg::VEL_W-1:0] vx,
    input logic signed [mwm_pkg::VEL_W-1:0] vy,
    input logic signed [mwm_pkg::VEL_W-1:0] wz
  );
    wheel_drive_t drive;
    longint lim;
    longint cx;
    longint cy;
    longint mix;
    longint target;
    longint lvl;
    longint mag;
    lim = longint'(limit_model);
    cx  = longint'(vx);
    cy  = longint'(vy);
    if (cx > lim) cx = lim;
    if (cx < -lim) cx = -lim;
    if (cy > lim) cy = lim;
    if (cy < -lim) cy = -lim;
    for (int w = 0; w < mwm_pkg::NUM_WHEELS; w++) begin
      mix = 256 * (mwm_pkg::VY_NEG[w] ? (cx - cy) : (cx + cy));
      if (mwm_pkg::WZ_NEG[w]) mix = mix - ROT_NUM * longint'(wz);
      else mix = mix + ROT_NUM * longint'(wz);
      // both quotients truncate toward zero
      target = (mix * 256) / 200;
      lvl    = (19 * longint'(level_model[w]) + target) / 20;
      level_model[w] = lvl[mwm_pkg::LEVEL_W-1:0];
      if (lvl > 0) begin
        drive.dir[w] = mwm_pkg::DIR_FWD;
        mag = lvl;
      end else if (lvl < 0) begin
        drive.dir[w] = mwm_pkg::DIR_REV;
        mag = -lvl;
      end else begin
        drive.dir[w] = mwm_pkg::DIR_STOP;
        mag = 0;
      end
      if (mag > DUTY_MAX) mag = DUTY_MAX;
      drive.duty[w] = mag[mwm_pkg::DUTY_W-1:0];
    end
    return drive;
  endfunction

  // result checker
  always @(posedge clk) begin
    wheel_drive_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_drive_q.size() == 0) begin
        $error("result transaction with nothing expected");
        mismatch_count++;
      end else begin
        want = pending_drive_q.pop_front();
        for (int w = 0; w < mwm_pkg::NUM_WHEELS; w++) begin
          if (seen_duty[w] !== want.duty[w]) begin
            $error("duty_%s expected %0d got %0d", wheel_name[w], want.duty[w], seen_duty[w]);
            mismatch_count++;
          end
          if (seen_dir[w] !== want.dir[w]) begin
            $error("dir_%s expected %0d got %0d", wheel_name[w], want.dir[w], seen_dir[w]);
            mismatch_count++;
          end
        end
      end
    end
  end

  // offer one command and wait for it to be taken
  task automatic send_velocity(input logic signed [mwm_pkg::VEL_W-1:0] vx,
                               input logic signed [mwm_pkg::VEL_W-1:0] vy,
                               input logic signed [mwm_pkg::VEL_W-1:0] wz);
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_vel_x <= vx;
    in_vel_y <= vy;
    in_rot_z <= wz;
    do @(posedge clk); while (in_stall);
    pending_drive_q.push_back(predict_wheel_drive(vx, vy, wz));
  endtask

  // stop offering and wait for every expected result
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_drive_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_speed_limit(input logic [mwm_pkg::LIMIT_W-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    limit_model = value;
  endtask

  // random velocity: full range, inside the limit, extremes or near zero
  function automatic logic signed [mwm_pkg::VEL_W-1:0] pick_velocity();
    int lim;
    lim = int'(limit_model);
    if (lim > 2047) lim = 2047;
    case ($urandom_range(0, 3))
      0: return mwm_pkg::VEL_W'($urandom_range(0, 4095));
      1: return mwm_pkg::VEL_W'($urandom_range(0, 2 * lim) - lim);
      2: begin
        case ($urandom_range(0, 3))
          0: return -12'sd2048;
          1: return 12'sd2047;
          2: return mwm_pkg::VEL_W'(lim);
          default: return mwm_pkg::VEL_W'(-lim);
        endcase
      end
      default: return mwm_pkg::VEL_W'($urandom_range(0, 16) - 8);
    endcase
  endfunction

  // random commands; a command is often held for several transactions so levels build up
  task automatic run_random_commands(input int count);
    logic signed [mwm_pkg::VEL_W-1:0] vx;
    logic signed [mwm_pkg::VEL_W-1:0] vy;
    logic signed [mwm_pkg::VEL_W-1:0] wz;
    vx = '0;
    vy = '0;
    wz = '0;
    repeat (count) begin
      if ($urandom_range(0, 99) >= 40) begin
        vx = pick_velocity();
        vy = pick_velocity();
        wz = pick_velocity();
      end
      send_velocity(vx, vy, wz);
    end
  endtask

  // zero levels after reset, wheels that stop alone, clamping at the reset limit
  task automatic test_reset_state_and_stops();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    send_velocity(12'sd0, 12'sd0, 12'sd0);
    send_velocity(12'sd80, 12'sd80, 12'sd0);
    send_velocity(12'sd80, -12'sd80, 12'sd0);
    send_velocity(12'sd0, 12'sd0, -12'sd5);
    send_velocity(12'sd2047, -12'sd2048, 12'sd1);
  endtask

  // hold full commands until the duty saturates, then swing the other way
  task automatic test_duty_saturation();
    repeat (10) send_velocity(12'sd2047, 12'sd2047, 12'sd2047);
    repeat (5) send_velocity(-12'sd2048, -12'sd2048, -12'sd2048);
  endtask

  // smallest and largest speed limits
  task automatic test_limit_extremes();
    write_speed_limit('0);
    send_velocity(12'sd2047, -12'sd2048, 12'sd0);
    send_velocity(-12'sd2048, 12'sd2047, -12'sd2048);
    write_speed_limit(11'd2047);
    send_velocity(12'sd2047, 12'sd2047, 12'sd2047);
    send_velocity(-12'sd2048, -12'sd2048, -12'sd2048);
    send_velocity(-12'sd2000, 12'sd2000, 12'sd1);
  endtask

  task automatic test_random_no_idling();
    write_speed_limit(11'd2000);
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    run_random_commands(300);
  endtask

  task automatic test_random_sender_idle();
    write_speed_limit(mwm_pkg::LIMIT_W'($urandom_range(0, 2047)));
    sender_idle_pct    = 59;
    receiver_stall_pct = 0;
    run_random_commands(300);
  endtask

  task automatic test_random_receiver_stall();
    write_speed_limit(11'd1);
    sender_idle_pct    = 0;
    receiver_stall_pct = 59;
    run_random_commands(300);
  endtask

  task automatic test_random_both_idle();
    write_speed_limit(11'd2047);
    sender_idle_pct    = 23;
    receiver_stall_pct = 23;
    run_random_commands(300);
  endtask

  // receiver holds off for a long stretch while commands keep coming
  task automatic test_backpressure_fill();
    write_speed_limit(mwm_pkg::LIMIT_W'($urandom_range(40, 400)));
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    @(posedge clk);
    -> long_hold_ev;
    run_random_commands(300);
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    in_valid           = 1'b0;
    in_vel_x           = '0;
    in_vel_y           = '0;
    in_rot_z           = '0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    limit_model        = mwm_pkg::SPEED_LIMIT_RESET;
    for (int w = 0; w < mwm_pkg::NUM_WHEELS; w++) level_model[w] = '0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state_and_stops();
    test_duty_saturation();
    test_limit_extremes();
    test_random_no_idling();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    test_backpressure_fill();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
